>>> hw/rtl/lpd_pkg.sv
`default_nettype none

package lpd_pkg;

  // field widths
  localparam int POS_W      = 16;
  localparam int GAIN_W     = 16;
  localparam int LEVEL_W    = 15;
  localparam int DUTY_W     = 16;
  localparam int OP_W       = 2;
  localparam int DIR_W      = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // shared multiplier, signed operands
  localparam int MUL_W  = 25;
  localparam int PROD_W = 2 * MUL_W;

  // integral clamp base, scaled by the position fraction bits
  localparam int INTEG_BASE = 1000;

  // duty = floor(level * full_duty / 25600) = floor((x >> 8) / 100)
  // x >> 8 stays below 2^23, so a 30 bit reciprocal of 100 is exact
  localparam int DUTY_PRE_SHIFT   = 8;
  localparam int DUTY_Y_W         = 23;
  localparam int DUTY_RECIP       = 10737419;
  localparam int DUTY_RECIP_SHIFT = 30;
  localparam int DUTY_Q_W         = 17;

  // opcodes
  localparam logic [OP_W-1:0] OP_TICK    = 2'd0;
  localparam logic [OP_W-1:0] OP_TARGET  = 2'd1;
  localparam logic [OP_W-1:0] OP_ENABLE  = 2'd2;
  localparam logic [OP_W-1:0] OP_DISABLE = 2'd3;

  // run direction codes
  localparam logic [DIR_W-1:0] DIR_NONE = 2'd0;
  localparam logic [DIR_W-1:0] DIR_UP   = 2'd1;
  localparam logic [DIR_W-1:0] DIR_DOWN = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LOWER    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_UPPER    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_STEP     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CEILING  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_DUTY     = 3'd7;

  // register reset values
  localparam logic [POS_W-1:0]   RST_LOWER   = 16'd432;
  localparam logic [POS_W-1:0]   RST_UPPER   = 16'd3760;
  localparam logic [LEVEL_W-1:0] RST_STEP    = 15'd1280;
  localparam logic [LEVEL_W-1:0] RST_CEILING = 15'd25600;
  localparam logic [DUTY_W-1:0]  RST_DUTY    = 16'd1000;

  typedef struct packed {
    logic signed [GAIN_W-1:0] gain_p;
    logic signed [GAIN_W-1:0] gain_i;
    logic signed [GAIN_W-1:0] gain_d;
    logic [POS_W-1:0]         lower_limit;
    logic [POS_W-1:0]         upper_limit;
    logic [LEVEL_W-1:0]       step_limit;
    logic [LEVEL_W-1:0]       output_ceiling;
    logic [DUTY_W-1:0]        full_duty;
  } lpd_cfg_t;

endpackage

`default_nettype wire

>>> hw/rtl/lpd_cfg_regs.sv
`default_nettype none

module lpd_cfg_regs
  import lpd_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  output lpd_cfg_t                   cfg_o
);

  lpd_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        REG_GAIN_P:  cfg_d.gain_p         = cfg_data_i;
        REG_GAIN_I:  cfg_d.gain_i         = cfg_data_i;
        REG_GAIN_D:  cfg_d.gain_d         = cfg_data_i;
        REG_LOWER:   cfg_d.lower_limit    = cfg_data_i;
        REG_UPPER:   cfg_d.upper_limit    = cfg_data_i;
        REG_STEP:    cfg_d.step_limit     = cfg_data_i[LEVEL_W-1:0];
        REG_CEILING: cfg_d.output_ceiling = cfg_data_i[LEVEL_W-1:0];
        REG_DUTY:    cfg_d.full_duty      = cfg_data_i;
        default:     cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain_p         <= '0;
      cfg_q.gain_i         <= '0;
      cfg_q.gain_d         <= '0;
      cfg_q.lower_limit    <= RST_LOWER;
      cfg_q.upper_limit    <= RST_UPPER;
      cfg_q.step_limit     <= RST_STEP;
      cfg_q.output_ceiling <= RST_CEILING;
      cfg_q.full_duty      <= RST_DUTY;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

>>> hw/rtl/lpd_mul_unit.sv
`default_nettype none

module lpd_mul_unit
  import lpd_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic signed [MUL_W-1:0]  a_i,
  input  wire logic signed [MUL_W-1:0]  b_i,
  output logic signed [PROD_W-1:0]      p_o
);

  logic signed [PROD_W-1:0] p_q;

  // product is registered: it lands in the cycle after the operands
  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

>>> hw/rtl/lift_position_pid_drive_unit.sv
// lift position pid drive
//
// input channel: in_valid_i / in_stall_o with opcode_i, measured_position_i and
// new_target_i; a request is taken at a clock edge with valid high and stall low.
// output channel: out_valid_o / out_stall_i with one result per request (duty
// per bridge channel, bridge enable, enable status, direction, drive level).
// configuration: cfg_we_i writes cfg_data_i into register cfg_index_i at once;
// write only while no request is in flight.
//
// one shared multiplier runs every product under a small sequencer: the three
// pid products, then level * full_duty, then the reciprocal multiply for / 100.
// a tick that runs the pid step goes through decide, three pid products,
// accumulate, clip, level, two duty passes, saturate and load before it is
// ready again. any other request, including a tick that stops or finds the
// block disabled, skips the pid steps and goes from decide to the duty passes.
// the result sits in an output register; while it is stalled the next request
// is still accepted and worked, and only its final load waits for the slot.
// reset: controller disabled, direction none, target, integral, last error and
// level zero, registers at their defaults, no result pending.
`default_nettype none

module lift_position_pid_drive_unit
  import lpd_pkg::*;
#(
  parameter int POSITION_FRAC_BITS = 4
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // config write port
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  // request channel
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [OP_W-1:0]       opcode_i,
  input  wire logic [POS_W-1:0]      measured_position_i,
  input  wire logic [POS_W-1:0]      new_target_i,
  // result channel
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic [DUTY_W-1:0]          duty_a_o,
  output logic [DUTY_W-1:0]          duty_b_o,
  output logic                       bridge_on_o,
  output logic                       is_enabled_o,
  output logic [DIR_W-1:0]           direction_o,
  output logic [LEVEL_W-1:0]         drive_level_o
);

  // integral clamp and datapath widths follow the position fraction bits
  localparam int ILIM   = INTEG_BASE << POSITION_FRAC_BITS;
  localparam int IW     = $clog2(ILIM + 1) + 1;
  localparam int TW     = (IW > 18) ? IW : 18;
  localparam int SUM_W  = GAIN_W + TW + 2;
  localparam int DERR_W = POS_W + 1;

  // sequencer states
  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_DECIDE = 4'd1;
  localparam logic [3:0] ST_INTEG  = 4'd2;
  localparam logic [3:0] ST_MUL_I  = 4'd3;
  localparam logic [3:0] ST_MUL_D  = 4'd4;
  localparam logic [3:0] ST_ACC    = 4'd5;
  localparam logic [3:0] ST_CLIP   = 4'd6;
  localparam logic [3:0] ST_LEVEL  = 4'd7;
  localparam logic [3:0] ST_DUTY_M = 4'd8;
  localparam logic [3:0] ST_DUTY_R = 4'd9;
  localparam logic [3:0] ST_DUTY_Q = 4'd10;
  localparam logic [3:0] ST_EMIT   = 4'd11;

  lpd_cfg_t cfg;

  lpd_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // shared multiplier
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] prod;

  lpd_mul_unit u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  // control state
  logic [3:0]         state_q, state_d;
  logic               en_q, en_d;
  logic [DIR_W-1:0]   dir_q, dir_d;
  logic [POS_W-1:0]   target_q, target_d;
  logic signed [IW-1:0] integ_q, integ_d;
  logic [POS_W-1:0]   prev_q, prev_d;
  logic [LEVEL_W-1:0] drive_q, drive_d;
  logic               out_valid_q, out_valid_d;

  // working registers
  logic [OP_W-1:0]    op_q, op_d;
  logic [POS_W-1:0]   pos_q, pos_d;
  logic [POS_W-1:0]   tgt_in_q, tgt_in_d;
  logic [POS_W-1:0]   err_q, err_d;
  logic signed [DERR_W-1:0] deriv_q, deriv_d;
  logic signed [SUM_W-1:0]  acc_q, acc_d;
  logic [DUTY_W-1:0]  duty_q, duty_d;

  // result registers
  logic [DUTY_W-1:0]  res_a_q, res_a_d, res_b_q, res_b_d;
  logic               res_en_q, res_en_d;
  logic [DIR_W-1:0]   res_dir_q, res_dir_d;
  logic [LEVEL_W-1:0] res_lvl_q, res_lvl_d;

  // comb helpers
  logic [DIR_W-1:0]        dir_n;
  logic                    stop_n;
  logic signed [TW:0]      isum, ilim_s;
  logic signed [SUM_W-1:0] shifted, step_s;
  logic signed [SUM_W:0]   lvl, ceil_s;
  logic [DUTY_Q_W-1:0]     quot;
  logic                    slot_free;

  assign slot_free = !out_valid_q || !out_stall_i;
  assign ilim_s    = (TW+1)'(ILIM);
  assign step_s    = SUM_W'(cfg.step_limit);
  assign ceil_s    = (SUM_W+1)'(cfg.output_ceiling);
  assign shifted   = acc_q >>> POSITION_FRAC_BITS;
  assign lvl       = (SUM_W+1)'(acc_q) + (SUM_W+1)'(drive_q);
  assign quot      = prod[DUTY_RECIP_SHIFT +: DUTY_Q_W];

  // direction latch and stop decision for a tick
  always_comb begin
    dir_n = dir_q;
    if (drive_q == '0) begin
      if (target_q > pos_q) begin
        dir_n = DIR_UP;
      end else if (target_q < pos_q) begin
        dir_n = DIR_DOWN;
      end
    end
    case (dir_n)
      DIR_UP:   stop_n = (pos_q >= target_q) || (pos_q >= cfg.upper_limit);
      DIR_DOWN: stop_n = (pos_q <= target_q) || (pos_q <= cfg.lower_limit);
      default:  stop_n = 1'b1;
    endcase
  end

  // operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_INTEG: begin
        mul_a = MUL_W'(cfg.gain_p);
        mul_b = MUL_W'(err_q);
      end
      ST_MUL_I: begin
        mul_a = MUL_W'(cfg.gain_i);
        mul_b = MUL_W'(integ_q);
      end
      ST_MUL_D: begin
        mul_a = MUL_W'(cfg.gain_d);
        mul_b = MUL_W'(deriv_q);
      end
      ST_DUTY_M: begin
        mul_a = MUL_W'(drive_q);
        mul_b = MUL_W'(cfg.full_duty);
      end
      ST_DUTY_R: begin
        mul_a = MUL_W'(prod[DUTY_PRE_SHIFT +: DUTY_Y_W]);
        mul_b = MUL_W'(DUTY_RECIP);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    en_d        = en_q;
    dir_d       = dir_q;
    target_d    = target_q;
    integ_d     = integ_q;
    prev_d      = prev_q;
    drive_d     = drive_q;
    out_valid_d = out_valid_q;
    op_d        = op_q;
    pos_d       = pos_q;
    tgt_in_d    = tgt_in_q;
    err_d       = err_q;
    deriv_d     = deriv_q;
    acc_d       = acc_q;
    duty_d      = duty_q;
    res_a_d     = res_a_q;
    res_b_d     = res_b_q;
    res_en_d    = res_en_q;
    res_dir_d   = res_dir_q;
    res_lvl_d   = res_lvl_q;
    isum        = (TW+1)'(integ_q) + (TW+1)'(err_q);

    // result taken downstream
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          op_d     = opcode_i;
          pos_d    = measured_position_i;
          tgt_in_d = new_target_i;
          state_d  = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        state_d = ST_DUTY_M;
        case (op_q)
          OP_TICK: begin
            if (!en_q) begin
              drive_d = '0;
            end else begin
              dir_d = dir_n;
              if (stop_n) begin
                en_d    = 1'b0;
                drive_d = '0;
              end else begin
                err_d   = (dir_n == DIR_UP) ? (target_q - pos_q) : (pos_q - target_q);
                state_d = ST_INTEG;
              end
            end
          end
          OP_TARGET: begin
            // lower clamp first, then upper, even if the limits cross
            if (tgt_in_q < cfg.lower_limit) begin
              target_d = cfg.lower_limit;
            end else if (tgt_in_q > cfg.upper_limit) begin
              target_d = cfg.upper_limit;
            end else begin
              target_d = tgt_in_q;
            end
            integ_d = '0;
            prev_d  = '0;
          end
          OP_ENABLE: begin
            en_d = 1'b1;
          end
          OP_DISABLE: begin
            en_d    = 1'b0;
            drive_d = '0;
          end
          default: begin
            en_d = en_q;
          end
        endcase
      end
      ST_INTEG: begin
        // p term issued this cycle; integral and derivative updated
        if (isum > ilim_s) begin
          integ_d = IW'(ilim_s);
        end else if (isum < -ilim_s) begin
          integ_d = IW'(-ilim_s);
        end else begin
          integ_d = IW'(isum);
        end
        deriv_d = signed'(DERR_W'(err_q)) - signed'(DERR_W'(prev_q));
        prev_d  = err_q;
        state_d = ST_MUL_I;
      end
      ST_MUL_I: begin
        acc_d   = SUM_W'(prod);
        state_d = ST_MUL_D;
      end
      ST_MUL_D: begin
        acc_d   = acc_q + SUM_W'(prod);
        state_d = ST_ACC;
      end
      ST_ACC: begin
        acc_d   = acc_q + SUM_W'(prod);
        state_d = ST_CLIP;
      end
      ST_CLIP: begin
        // floor shift, then limit the rise per tick
        acc_d   = (shifted > step_s) ? step_s : shifted;
        state_d = ST_LEVEL;
      end
      ST_LEVEL: begin
        if (lvl > ceil_s) begin
          drive_d = cfg.output_ceiling;
        end else if (lvl < 0) begin
          drive_d = '0;
        end else begin
          drive_d = lvl[LEVEL_W-1:0];
        end
        state_d = ST_DUTY_M;
      end
      ST_DUTY_M: begin
        state_d = ST_DUTY_R;
      end
      ST_DUTY_R: begin
        state_d = ST_DUTY_Q;
      end
      ST_DUTY_Q: begin
        duty_d  = (quot > DUTY_Q_W'(16'hFFFF)) ? 16'hFFFF : quot[DUTY_W-1:0];
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (slot_free) begin
          res_a_d     = (en_q && drive_q != '0 && dir_q == DIR_UP) ? duty_q : '0;
          res_b_d     = (en_q && drive_q != '0 && dir_q == DIR_DOWN) ? duty_q : '0;
          res_en_d    = en_q;
          res_dir_d   = dir_q;
          res_lvl_d   = drive_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      en_q        <= 1'b0;
      dir_q       <= DIR_NONE;
      target_q    <= '0;
      integ_q     <= '0;
      prev_q      <= '0;
      drive_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      en_q        <= en_d;
      dir_q       <= dir_d;
      target_q    <= target_d;
      integ_q     <= integ_d;
      prev_q      <= prev_d;
      drive_q     <= drive_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    pos_q     <= pos_d;
    tgt_in_q  <= tgt_in_d;
    err_q     <= err_d;
    deriv_q   <= deriv_d;
    acc_q     <= acc_d;
    duty_q    <= duty_d;
    res_a_q   <= res_a_d;
    res_b_q   <= res_b_d;
    res_en_q  <= res_en_d;
    res_dir_q <= res_dir_d;
    res_lvl_q <= res_lvl_d;
  end

  assign in_stall_o    = (state_q != ST_IDLE);
  assign out_valid_o   = out_valid_q;
  assign duty_a_o      = res_a_q;
  assign duty_b_o      = res_b_q;
  assign bridge_on_o   = res_en_q;
  assign is_enabled_o  = res_en_q;
  assign direction_o   = res_dir_q;
  assign drive_level_o = res_lvl_q;

  // a nonzero level only exists while enabled
  a_level_needs_enable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    drive_q != '0 |-> en_q)
    else $error("drive level nonzero while disabled");

  // integral stays inside its clamp
  a_integ_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (integ_q <= IW'(ILIM)) && (integ_q >= -(IW'(ILIM))))
    else $error("integral outside clamp");

  // an accepted request starts the sequencer
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> state_q == ST_DECIDE)
    else $error("accepted request did not start");

  // never drive both bridge channels
  a_one_channel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (res_a_q == '0 || res_b_q == '0))
    else $error("both duty channels active");

endmodule

`default_nettype wire
